### rtl/bfga_pkg.sv
// ----------------------------------------------------------------------------
// Glyph address package
// Widths, register indexes, codes and shared types of the glyph address block.
// ----------------------------------------------------------------------------
package bfga_pkg;

  // Default depth of the block table.
  localparam int unsigned MaxBlocksDefault = 256;

  // Field widths.
  localparam int CODE_W     = 16;
  localparam int IDX_W      = 8;
  localparam int LEN_W      = 13;
  localparam int FILE_W     = 32;
  localparam int DIM_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BASE_W     = 11;

  // Offset of the first glyph in a single-byte font.
  localparam int HeaderBase = 17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH  = 3'd3;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0]  RESET_GLYPH_WIDTH  = 8'd16;
  localparam logic [DIM_W-1:0]  RESET_GLYPH_HEIGHT = 8'd16;
  localparam logic [IDX_W-1:0]  RESET_BLOCK_COUNT  = 8'd0;
  localparam logic [FILE_W-1:0] RESET_FILE_LENGTH  = 32'd0;

  // Command codes.
  localparam logic ACTION_WRITE  = 1'b0;
  localparam logic ACTION_LOOKUP = 1'b1;

  // Status codes.
  localparam logic STATUS_FOUND   = 1'b0;
  localparam logic STATUS_MISSING = 1'b1;

  // Write of one block entry, broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] last;
  } entry_wr_t;

  // Control part of the lookup word that travels down the chain.
  typedef struct packed {
    logic valid;
    logic stop;
  } walk_ctl_t;

  // Bitmap length: whole bytes per row times rows.
  function automatic logic [LEN_W-1:0] glyph_len(input logic [DIM_W-1:0] width,
                                                 input logic [DIM_W-1:0] height);
    logic [DIM_W:0]   padded;
    logic [DIM_W-3:0] row_bytes;
    logic [DIM_W*2-3:0] product;
    padded    = {1'b0, width} + (DIM_W+1)'(7);
    row_bytes = padded[DIM_W:3];
    product   = row_bytes * height;
    return product[LEN_W-1:0];
  endfunction

endpackage

### rtl/bitmap_font_glyph_address.sv
// ----------------------------------------------------------------------------
// Bitmap font glyph address
// Finds the byte offset and length of a glyph bitmap in a font file.
// ----------------------------------------------------------------------------
// A command with action high looks up char_code; it is taken when start is
// high and busy is low, and its word appears on the result ports for one cycle
// with done high. Busy drops in that same cycle, so a new lookup can be taken
// while the result is shown; no lookup is taken while busy is high. The lookup
// word passes one block cell per cycle through a row of MAX_BLOCKS cells, then
// one multiply stage and one add-and-compare stage. A command with action low
// writes one block entry, gives no result and does not raise busy; an index at
// or above MAX_BLOCKS is ignored. The receiver has no way to stall: each
// result must be taken in the cycle done is high. Configuration writes are
// taken at any edge with cfg_write high and must be made only while no lookup
// is in progress.
module bitmap_font_glyph_address #(
  parameter int unsigned MAX_BLOCKS = bfga_pkg::MaxBlocksDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             action,
  input  logic [bfga_pkg::IDX_W-1:0]       block_index,
  input  logic [bfga_pkg::CODE_W-1:0]      range_start,
  input  logic [bfga_pkg::CODE_W-1:0]      range_end,
  input  logic [bfga_pkg::CODE_W-1:0]      char_code,
  output logic                             done,
  output logic [bfga_pkg::FILE_W-1:0]      glyph_offset,
  output logic [bfga_pkg::LEN_W-1:0]       glyph_bytes,
  output logic                             status,
  input  logic                             cfg_write,
  input  logic [bfga_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfga_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bfga_pkg::*;

  // The sum grows by at most 65536 per block, signed.
  localparam int SUM_W  = $clog2(MAX_BLOCKS) + CODE_W + 2;
  localparam int PROD_W = SUM_W + LEN_W + 1;
  localparam int OFF_W  = PROD_W + 2;

  // Configuration registers.
  logic [DIM_W-1:0]  glyph_width;
  logic [DIM_W-1:0]  glyph_height;
  logic [IDX_W-1:0]  block_count;
  logic [FILE_W-1:0] file_length;

  // Command decode.
  logic      accept;
  logic      lookup_accept;
  entry_wr_t entry_wr;

  // Lookup word at the head of the chain and the values held for the lookup.
  walk_ctl_t               head_ctl;
  logic signed [SUM_W-1:0] head_sum;
  logic [CODE_W-1:0]       code_q;
  logic [LEN_W-1:0]        len_q;

  // Chain links: link 0 is the head, link MAX_BLOCKS is the tail.
  walk_ctl_t               ctl_link [0:MAX_BLOCKS];
  logic signed [SUM_W-1:0] sum_link [0:MAX_BLOCKS];

  // Multiply stage and offset stage.
  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod_q;
  logic [BASE_W-1:0]        base_q;
  logic signed [LEN_W:0]    len_s;
  logic signed [OFF_W-1:0]  offset_sum;
  logic                     found;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= RESET_GLYPH_WIDTH;
      glyph_height <= RESET_GLYPH_HEIGHT;
      block_count  <= RESET_BLOCK_COUNT;
      file_length  <= RESET_FILE_LENGTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[DIM_W-1:0];
        REG_GLYPH_HEIGHT: glyph_height <= cfg_data[DIM_W-1:0];
        REG_BLOCK_COUNT:  block_count  <= cfg_data[IDX_W-1:0];
        REG_FILE_LENGTH:  file_length  <= cfg_data[FILE_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept        = start && !busy;
  assign lookup_accept = accept && (action == ACTION_LOOKUP);

  // Block entry writes go to every cell; the matching cell stores it.
  assign entry_wr.en    = accept && (action == ACTION_WRITE);
  assign entry_wr.index = block_index;
  assign entry_wr.first = range_start;
  assign entry_wr.last  = range_end;

  // Launch a lookup word. In single-byte mode no cell is active and the
  // code itself is the glyph count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ctl <= '0;
    end else begin
      head_ctl.valid <= lookup_accept;
      head_ctl.stop  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_accept) begin
      head_sum <= (block_count == '0) ? $signed(SUM_W'(char_code)) : '0;
      code_q   <= char_code;
      len_q    <= glyph_len(glyph_width, glyph_height);
    end
  end

  assign ctl_link[0] = head_ctl;
  assign sum_link[0] = head_sum;

  // Row of block cells.
  for (genvar c = 0; c < MAX_BLOCKS; c++) begin : g_cell
    bfga_cell #(
      .SUM_W      (SUM_W),
      .CELL_INDEX (c)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .wr          (entry_wr),
      .code        (code_q),
      .block_count (block_count),
      .ctl_in      (ctl_link[c]),
      .sum_in      (sum_link[c]),
      .ctl_out     (ctl_link[c+1]),
      .sum_out     (sum_link[c+1])
    );
  end

  // Multiply the glyph count by the bitmap length; pick the header size.
  assign len_s = $signed({1'b0, len_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl_link[MAX_BLOCKS].valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= len_s * sum_link[MAX_BLOCKS];
    if (block_count == '0) begin
      base_q <= BASE_W'(HeaderBase);
    end else begin
      base_q <= BASE_W'(HeaderBase + 1) + {1'b0, block_count, 2'b00};
    end
  end

  // Final offset and its range check against the file.
  assign offset_sum = OFF_W'(prod_q) + $signed(OFF_W'(base_q));
  assign found      = (offset_sum >= $signed(OFF_W'(HeaderBase))) &&
                      (offset_sum <= $signed(OFF_W'(file_length)));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      busy <= 1'b0;
    end else begin
      done <= prod_valid;
      if (lookup_accept) begin
        busy <= 1'b1;
      end else if (prod_valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      glyph_offset <= found ? offset_sum[FILE_W-1:0] : '0;
      glyph_bytes  <= len_q;
      status       <= found ? STATUS_FOUND : STATUS_MISSING;
    end
  end

endmodule

### rtl/bfga_cell.sv
// ----------------------------------------------------------------------------
// Glyph address chain cell
// Holds one code-range block and applies it to the lookup word passing by.
// ----------------------------------------------------------------------------
module bfga_cell #(
  parameter int SUM_W      = 26,
  parameter int CELL_INDEX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bfga_pkg::entry_wr_t          wr,
  input  logic [bfga_pkg::CODE_W-1:0]  code,
  input  logic [bfga_pkg::IDX_W-1:0]   block_count,
  input  bfga_pkg::walk_ctl_t          ctl_in,
  input  logic signed [SUM_W-1:0]      sum_in,
  output bfga_pkg::walk_ctl_t          ctl_out,
  output logic signed [SUM_W-1:0]      sum_out
);
  import bfga_pkg::*;

  logic [CODE_W-1:0]       first_q;
  logic [CODE_W-1:0]       last_q;
  logic                    active;
  logic                    code_le_first;
  logic                    code_gt_last;
  logic signed [CODE_W+1:0] full_len;
  logic signed [CODE_W+1:0] part_len;
  logic signed [CODE_W+1:0] term;
  walk_ctl_t               ctl_next;
  logic signed [SUM_W-1:0] sum_next;

  // Block entry storage, written when the broadcast index matches this cell.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.index == IDX_W'(CELL_INDEX))) begin
      first_q <= wr.first;
      last_q  <= wr.last;
    end
  end

  // Only the first block_count cells take part in the walk.
  assign active        = IDX_W'(CELL_INDEX) < block_count;
  assign code_le_first = code <= first_q;
  assign code_gt_last  = code > last_q;

  // A block wholly below the code adds its length, otherwise the code's place in it.
  assign full_len = $signed({2'b00, last_q}) - $signed({2'b00, first_q}) + 18'sd1;
  assign part_len = $signed({2'b00, code}) - $signed({2'b00, first_q});
  assign term     = code_gt_last ? full_len : part_len;

  // Update of the passing word; the walk stops at the first block at or above the code.
  always_comb begin
    ctl_next = ctl_in;
    sum_next = sum_in;
    if (ctl_in.valid && !ctl_in.stop && active) begin
      if (code_le_first) begin
        ctl_next.stop = 1'b1;
      end else begin
        sum_next = sum_in + SUM_W'(term);
      end
    end
  end

  // Hand the word to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    sum_out <= sum_next;
  end

endmodule

### rtl/bfga_checker.sv
// ----------------------------------------------------------------------------
// Glyph address port checker
// Watches the command and result ports of the glyph address block over time.
// ----------------------------------------------------------------------------
module bfga_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             action,
  input logic                             done,
  input logic [bfga_pkg::FILE_W-1:0]      glyph_offset,
  input logic                             status
);
  import bfga_pkg::*;

  // A result word only closes a lookup that was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a lookup in progress");

  // The block is free again while its result word is shown.
  a_free_on_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high with the result word");

  // A lookup that is taken occupies the block.
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACTION_LOOKUP)) |=> busy)
    else $error("lookup taken but busy did not rise");

  // A missing glyph reports a zero offset; a found one lies at or above HeaderBase.
  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_MISSING)) |-> (glyph_offset == '0))
    else $error("missing glyph with a nonzero offset");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_FOUND)) |-> (glyph_offset >= FILE_W'(HeaderBase)))
    else $error("found glyph offset inside the header");

endmodule

bind bitmap_font_glyph_address bfga_checker u_bfga_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .done         (done),
  .glyph_offset (glyph_offset),
  .status       (status)
);
